### rtl/core/rvr_pkg.sv
// Package: types, constants and helper functions of the Rodrigues vector rotation block.
`timescale 1ns / 1ps
package rvr_pkg;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_VEC  = 2'd1,
      STATUS_ZERO_AXIS = 2'd2,
      STATUS_SATURATED = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
      logic signed [31:0] axis_x;
      logic signed [31:0] axis_y;
      logic signed [31:0] axis_z;
      logic signed [31:0] turn_angle;
   } req_type;

   typedef struct packed {
      logic signed [31:0] rot_x;
      logic signed [31:0] rot_y;
      logic signed [31:0] rot_z;
      status_type         status;
   } rsp_type;

   // Special cases decided at entry; they travel with each item.
   typedef struct packed {
      logic zero_vec;
      logic zero_axis;
   } flags_type;

   localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [33:0] ANG_TWO_PI  = 34'sd1686629713;
   localparam logic signed [33:0] ANG_PI      = 34'sd843314857;
   localparam logic signed [33:0] ANG_HALF_PI = 34'sd421657428;

   function automatic logic signed [33:0] atan_q28(input int unsigned idx);
      logic signed [33:0] r;
      case (idx)
         0:  r = 34'sd210828714;
         1:  r = 34'sd124459457;
         2:  r = 34'sd65760959;
         3:  r = 34'sd33381290;
         4:  r = 34'sd16755422;
         5:  r = 34'sd8385879;
         6:  r = 34'sd4193963;
         7:  r = 34'sd2097109;
         8:  r = 34'sd1048571;
         9:  r = 34'sd524287;
         10: r = 34'sd262144;
         11: r = 34'sd131072;
         12: r = 34'sd65536;
         13: r = 34'sd32768;
         14: r = 34'sd16384;
         15: r = 34'sd8192;
         16: r = 34'sd4096;
         17: r = 34'sd2048;
         18: r = 34'sd1024;
         19: r = 34'sd512;
         20: r = 34'sd256;
         21: r = 34'sd128;
         22: r = 34'sd64;
         23: r = 34'sd32;
         24: r = 34'sd16;
         25: r = 34'sd8;
         26: r = 34'sd4;
         27: r = 34'sd2;
         28: r = 34'sd1;
         default: r = 34'sd0;
      endcase
      return r;
   endfunction

endpackage

### rtl/core/rvr_stream_if.sv
// Valid/ready stream interface carrying one payload of a given type.
`timescale 1ns / 1ps
interface rvr_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/rvr_cordic.sv
// Pipelined rotation-mode CORDIC giving clamped cos and sin of a Q4.28 angle.
`timescale 1ns / 1ps
module rvr_cordic #(
   parameter int ROTATION_STEPS = 24
) (
   input  logic                    clock,
   input  logic                    enable,
   input  logic signed [31:0]      angle,
   output logic signed [31:0]      cos_out,
   output logic signed [31:0]      sin_out
);
   import rvr_pkg::*;

   localparam int N = ROTATION_STEPS;

   logic signed [33:0] x_ff [0:N];
   logic signed [33:0] y_ff [0:N];
   logic signed [33:0] z_ff [0:N];
   logic               flip_ff [0:N];
   logic signed [33:0] red_in;
   logic signed [33:0] fold_in;
   logic               flip_in;
   logic signed [33:0] xc_in;
   logic signed [33:0] yc_in;

   always_comb begin
      red_in = 34'(angle);
      if (red_in > ANG_PI) red_in = red_in - ANG_TWO_PI;
      if (red_in < -ANG_PI) red_in = red_in + ANG_TWO_PI;
      fold_in = red_in;
      flip_in = 1'b0;
      if (red_in > ANG_HALF_PI) begin
         fold_in = ANG_PI - red_in;
         flip_in = 1'b1;
      end
      if (red_in < -ANG_HALF_PI) begin
         fold_in = -ANG_PI - red_in;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]    <= CORDIC_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= fold_in;
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (enable) begin
            flip_ff[i+1] <= flip_ff[i];
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_q28(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_q28(i);
            end
         end
      end
   end

   always_comb begin
      xc_in = x_ff[N];
      yc_in = y_ff[N];
      if (xc_in > Q30_ONE) xc_in = Q30_ONE;
      if (xc_in < -Q30_ONE) xc_in = -Q30_ONE;
      if (yc_in > Q30_ONE) yc_in = Q30_ONE;
      if (yc_in < -Q30_ONE) yc_in = -Q30_ONE;
      if (flip_ff[N]) xc_in = -xc_in;
   end

   assign cos_out = xc_in[31:0];
   assign sin_out = yc_in[31:0];
endmodule

### rtl/core/rvr_axis_norm.sv
// Pipelined axis normalisation: scaling, sum of squares, square root and divisions.
`timescale 1ns / 1ps
module rvr_axis_norm (
   input  logic               clock,
   input  logic               enable,
   input  logic signed [31:0] ax,
   input  logic signed [31:0] ay,
   input  logic signed [31:0] az,
   output logic signed [31:0] kx,
   output logic signed [31:0] ky,
   output logic signed [31:0] kz
);
   import rvr_pkg::*;

   // Stages: 1 scale + 1 square + 1 sum + 1 root load + 32 root + 1 divide load
   // + 31 divide stages, 68 in all.
   localparam int RS = 32;
   localparam int DS = 31;

   logic [32:0] mag_in [3];
   logic [32:0] mx_in;
   logic [5:0]  lz_in;
   logic [29:0] sc_in [3];

   logic [29:0] m1_ff [3];
   logic [2:0]  s1_ff;
   logic [59:0] sq_ff [3];
   logic [29:0] m2_ff [3];
   logic [2:0]  s2_ff;
   logic [61:0] sum_ff;
   logic [29:0] m3_ff [3];
   logic [2:0]  s3_ff;

   logic [63:0] rv_ff  [0:RS];
   logic [63:0] rr_ff  [0:RS];
   logic [63:0] rb_ff  [0:RS];
   logic [29:0] rm_ff  [0:RS][3];
   logic [2:0]  rs_ff  [0:RS];

   logic [30:0] rem_ff [0:DS][3];
   logic [30:0] q_ff   [0:DS][3];
   logic [29:0] dm_ff  [0:DS][3];
   logic [31:0] dn_ff  [0:DS];
   logic [2:0]  ds_ff  [0:DS];

   always_comb begin
      mag_in[0] = ax[31] ? 33'(-34'(ax)) : 33'(ax);
      mag_in[1] = ay[31] ? 33'(-34'(ay)) : 33'(ay);
      mag_in[2] = az[31] ? 33'(-34'(az)) : 33'(az);
      mx_in = mag_in[0];
      if (mag_in[1] > mx_in) mx_in = mag_in[1];
      if (mag_in[2] > mx_in) mx_in = mag_in[2];
      lz_in = '0;
      for (int b = 0; b <= 32; b++)
         if (mx_in[b]) lz_in = 6'(b);
      // Bring the largest magnitude into bit 29.
      for (int j = 0; j < 3; j++) begin
         if (lz_in > 6'd29) sc_in[j] = 30'(mag_in[j] >> (lz_in - 6'd29));
         else               sc_in[j] = 30'(mag_in[j] << (6'd29 - lz_in));
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         m1_ff <= sc_in;
         s1_ff <= {az[31], ay[31], ax[31]};
         for (int j = 0; j < 3; j++) sq_ff[j] <= 60'(m1_ff[j]) * 60'(m1_ff[j]);
         m2_ff <= m1_ff;
         s2_ff <= s1_ff;
         sum_ff <= 62'(sq_ff[0]) + 62'(sq_ff[1]) + 62'(sq_ff[2]);
         m3_ff <= m2_ff;
         s3_ff <= s2_ff;
         rv_ff[0] <= 64'(sum_ff);
         rr_ff[0] <= '0;
         rb_ff[0] <= 64'h4000_0000_0000_0000;
         rm_ff[0] <= m3_ff;
         rs_ff[0] <= s3_ff;
      end
   end

   // Restoring square root, one result bit per stage.
   for (genvar i = 0; i < RS; i++) begin : g_root
      logic [64:0] t;
      assign t = 65'(rr_ff[i]) + 65'(rb_ff[i]);
      always_ff @(posedge clock) begin
         if (enable) begin
            if (65'(rv_ff[i]) >= t) begin
               rv_ff[i+1] <= rv_ff[i] - t[63:0];
               rr_ff[i+1] <= 64'((65'(rr_ff[i]) >> 1) + 65'(rb_ff[i]));
            end else begin
               rv_ff[i+1] <= rv_ff[i];
               rr_ff[i+1] <= rr_ff[i] >> 1;
            end
            rb_ff[i+1] <= rb_ff[i] >> 2;
            rm_ff[i+1] <= rm_ff[i];
            rs_ff[i+1] <= rs_ff[i];
         end
      end
   end

   // The upper bits of mag << 30, shifted down by 31, are already below the
   // root, so they seed the remainder and only the low 31 bits are divided.
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int j = 0; j < 3; j++) begin
            rem_ff[0][j] <= 31'(rm_ff[RS][j] >> 1);
            q_ff[0][j]   <= '0;
         end
         dm_ff[0] <= rm_ff[RS];
         dn_ff[0] <= rr_ff[RS][31:0];
         ds_ff[0] <= rs_ff[RS];
      end
   end

   // Restoring division of mag << 30 by the root; quotient stays below 2^31
   // because the root is at least the largest magnitude.
   for (genvar i = 0; i < DS; i++) begin : g_div
      for (genvar j = 0; j < 3; j++) begin : g_lane
         logic [31:0] tr;
         assign tr = {rem_ff[i][j], (i == 0) ? dm_ff[i][j][0] : 1'b0};
         always_ff @(posedge clock) begin
            if (enable) begin
               if (tr >= dn_ff[i]) begin
                  rem_ff[i+1][j] <= 31'(tr - dn_ff[i]);
                  q_ff[i+1][j]   <= {q_ff[i][j][29:0], 1'b1};
               end else begin
                  rem_ff[i+1][j] <= tr[30:0];
                  q_ff[i+1][j]   <= {q_ff[i][j][29:0], 1'b0};
               end
               dm_ff[i+1][j] <= dm_ff[i][j];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            dn_ff[i+1] <= dn_ff[i];
            ds_ff[i+1] <= ds_ff[i];
         end
      end
   end

   assign kx = ds_ff[DS][0] ? -$signed({1'b0, q_ff[DS][0]}) : $signed({1'b0, q_ff[DS][0]});
   assign ky = ds_ff[DS][1] ? -$signed({1'b0, q_ff[DS][1]}) : $signed({1'b0, q_ff[DS][1]});
   assign kz = ds_ff[DS][2] ? -$signed({1'b0, q_ff[DS][2]}) : $signed({1'b0, q_ff[DS][2]});
endmodule

### rtl/core/rvr_rotate.sv
// Pipelined Rodrigues combination of unit axis, vector, cos and sin.
`timescale 1ns / 1ps
module rvr_rotate (
   input  logic               clock,
   input  logic               enable,
   input  logic signed [31:0] k [3],
   input  logic signed [31:0] v [3],
   input  logic signed [31:0] cs,
   input  logic signed [31:0] sn,
   output logic signed [31:0] r [3],
   output logic               sat
);
   import rvr_pkg::*;

   // Six stages: products, dot and cross sums, parallel part, trig products,
   // final sum, saturation.
   logic signed [63:0] kv_ff [3][3];
   logic signed [31:0] v1_ff [3], k1_ff [3], cs1_ff, sn1_ff;
   logic signed [35:0] d2_ff;
   logic signed [35:0] c2_ff [3];
   logic signed [31:0] v2_ff [3], k2_ff [3], cs2_ff, sn2_ff;
   logic signed [35:0] p3_ff [3];
   logic signed [36:0] pe3_ff [3];
   logic signed [35:0] c3_ff [3];
   logic signed [31:0] cs3_ff, sn3_ff;
   logic signed [71:0] a4_ff [3], b4_ff [3];
   logic signed [35:0] p4_ff [3];
   logic signed [43:0] r5_ff [3];
   logic signed [31:0] r6_ff [3];
   logic               sat6_ff;
   logic signed [31:0] r6_in [3];
   logic               sat6_in;

   function automatic logic signed [43:0] rnd30(input logic signed [73:0] x);
      logic signed [73:0] t;
      t = (x + 74'sd536870912) >>> 30;
      return t[43:0];
   endfunction

   always_comb begin
      sat6_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (r5_ff[i] > 44'sd2147483647) begin
            r6_in[i] = 32'sh7fffffff;
            sat6_in  = 1'b1;
         end else if (r5_ff[i] < -44'sd2147483648) begin
            r6_in[i] = 32'sh80000000;
            sat6_in  = 1'b1;
         end else begin
            r6_in[i] = r5_ff[i][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) kv_ff[i][j] <= 64'(k[i]) * 64'(v[j]);
         v1_ff <= v; k1_ff <= k; cs1_ff <= cs; sn1_ff <= sn;

         d2_ff    <= 36'(rnd30(74'(kv_ff[0][0]) + 74'(kv_ff[1][1]) + 74'(kv_ff[2][2])));
         c2_ff[0] <= 36'(rnd30(74'(kv_ff[1][2]) - 74'(kv_ff[2][1])));
         c2_ff[1] <= 36'(rnd30(74'(kv_ff[2][0]) - 74'(kv_ff[0][2])));
         c2_ff[2] <= 36'(rnd30(74'(kv_ff[0][1]) - 74'(kv_ff[1][0])));
         v2_ff <= v1_ff; k2_ff <= k1_ff; cs2_ff <= cs1_ff; sn2_ff <= sn1_ff;

         for (int i = 0; i < 3; i++) begin
            p3_ff[i]  <= 36'(rnd30(74'(k2_ff[i]) * 74'(d2_ff)));
            pe3_ff[i] <= 37'(v2_ff[i]) - 37'(rnd30(74'(k2_ff[i]) * 74'(d2_ff)));
         end
         c3_ff <= c2_ff; cs3_ff <= cs2_ff; sn3_ff <= sn2_ff;

         for (int i = 0; i < 3; i++) begin
            a4_ff[i] <= 72'(pe3_ff[i]) * 72'(cs3_ff);
            b4_ff[i] <= 72'(c3_ff[i]) * 72'(sn3_ff);
         end
         p4_ff <= p3_ff;

         for (int i = 0; i < 3; i++)
            r5_ff[i] <= rnd30(74'(a4_ff[i])) + rnd30(74'(b4_ff[i])) + 44'(p4_ff[i]);

         r6_ff   <= r6_in;
         sat6_ff <= sat6_in;
      end
   end

   assign r   = r6_ff;
   assign sat = sat6_ff;
endmodule

### rtl/core/rodrigues_vector_rotation.sv
// Top level of the pipelined Rodrigues vector rotation block.
`timescale 1ns / 1ps
// Rotates a Q16.16 vector about an arbitrary, non-unit Q16.16 axis by a Q4.28
// angle in radians. The block is one pipeline of 74 stages: 68 for axis
// normalisation (square root and divide, one bit per stage) and 6 for the
// Rodrigues combination, with the CORDIC for cos and sin running alongside.
// It takes one transfer every cycle unless the result side stalls; each
// result is held in the output register. A stall on the result side
// freezes the whole pipeline. Status reports a zero vector, a zero axis (the
// vector is then returned unchanged) or a saturated component.
module rodrigues_vector_rotation #(
   parameter int ROTATION_STEPS = 24
) (
   input  logic         clock,
   input  logic         reset,
   rvr_stream_if.sink   req,
   rvr_stream_if.source rsp
);
   import rvr_pkg::*;

   localparam int NORM_LAT = 68;
   localparam int ROT_LAT  = 6;
   localparam int LAT      = NORM_LAT + ROT_LAT;
   localparam int CWAIT    = NORM_LAT - ROTATION_STEPS - 2;

   logic               enable;
   logic               vld_ff [0:LAT];
   flags_type          fl_ff [0:LAT];
   logic signed [31:0] v_ff  [0:LAT][3];
   logic signed [31:0] kx, ky, kz;
   logic signed [31:0] cs_w, sn_w;
   logic signed [31:0] cs_ff [0:CWAIT];
   logic signed [31:0] sn_ff [0:CWAIT];
   logic signed [31:0] kk [3];
   logic signed [31:0] vv [3];
   logic signed [31:0] rr [3];
   logic               sat;
   req_type            rq;
   rsp_type            out_ff;
   logic               out_vld_ff;
   rsp_type            out_in;

   assign rq     = req.payload;
   assign enable = !out_vld_ff || rsp.ready;
   assign req.ready = enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAT; i++) vld_ff[i] <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= req.valid;
         for (int i = 1; i <= LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         v_ff[0][0] <= rq.vec_x;
         v_ff[0][1] <= rq.vec_y;
         v_ff[0][2] <= rq.vec_z;
         fl_ff[0].zero_vec  <= rq.vec_x == 0 && rq.vec_y == 0 && rq.vec_z == 0;
         fl_ff[0].zero_axis <= rq.axis_x == 0 && rq.axis_y == 0 && rq.axis_z == 0;
         for (int i = 1; i <= LAT; i++) begin
            v_ff[i]  <= v_ff[i-1];
            fl_ff[i] <= fl_ff[i-1];
         end
      end
   end

   rvr_axis_norm u_norm (
      .clock, .enable,
      .ax(rq.axis_x), .ay(rq.axis_y), .az(rq.axis_z),
      .kx, .ky, .kz
   );

   rvr_cordic #(.ROTATION_STEPS(ROTATION_STEPS)) u_cordic (
      .clock, .enable, .angle(rq.turn_angle), .cos_out(cs_w), .sin_out(sn_w)
   );

   // Delay the trig values so they meet the unit axis.
   always_ff @(posedge clock) begin
      if (enable) begin
         cs_ff[0] <= cs_w;
         sn_ff[0] <= sn_w;
         for (int i = 1; i <= CWAIT; i++) begin
            cs_ff[i] <= cs_ff[i-1];
            sn_ff[i] <= sn_ff[i-1];
         end
      end
   end

   assign kk[0] = kx;
   assign kk[1] = ky;
   assign kk[2] = kz;
   assign vv    = v_ff[NORM_LAT-1];

   rvr_rotate u_rot (
      .clock, .enable, .k(kk), .v(vv),
      .cs(cs_ff[CWAIT]), .sn(sn_ff[CWAIT]), .r(rr), .sat
   );

   always_comb begin
      out_in.rot_x  = rr[0];
      out_in.rot_y  = rr[1];
      out_in.rot_z  = rr[2];
      out_in.status = sat ? STATUS_SATURATED : STATUS_OK;
      if (fl_ff[LAT-1].zero_vec) begin
         out_in.rot_x  = '0;
         out_in.rot_y  = '0;
         out_in.rot_z  = '0;
         out_in.status = STATUS_ZERO_VEC;
      end else if (fl_ff[LAT-1].zero_axis) begin
         out_in.rot_x  = v_ff[LAT-1][0];
         out_in.rot_y  = v_ff[LAT-1][1];
         out_in.rot_z  = v_ff[LAT-1][2];
         out_in.status = STATUS_ZERO_AXIS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (enable) begin
         out_vld_ff <= vld_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) out_ff <= out_in;
   end

   assign rsp.valid   = out_vld_ff;
   assign rsp.payload = out_ff;
endmodule
